>>> rtl/lshs_pkg.sv
// Shared types, codes and helpers for the limit switch homing sequencer.
// Depends on nothing; RTL files use it by scoped name, the testbench imports it.
package lshs_pkg;

    localparam int JOINTS = 6;
    localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int RES_MAX = 3;

    localparam logic [30:0] BACKOFF_RESET = 31'd458752;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_ABORT = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_JOG     = 3'd1,
        CMD_STOPJOG = 3'd2,
        CMD_MOVE    = 3'd3,
        CMD_SETPOS  = 3'd4,
        CMD_DONE    = 3'd5,
        CMD_STOPALL = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        REG_JOINT_MIN   = 3'd0,
        REG_JOINT_MAX   = 3'd1,
        REG_HOME_OFFSET = 3'd2,
        REG_MAX_FAST    = 3'd3,
        REG_MAX_SLOW    = 3'd4,
        REG_BACKOFF     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        op_t         opcode;
        logic [2:0]  joint;
        logic [30:0] req_fast;
        logic [30:0] req_slow;
        logic        limit_hit;
        logic        joint_moving;
        logic        estop;
    } item_t;

    typedef struct packed {
        cmd_t               command;
        logic [2:0]         target_joint;
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic [30:0]        accel;
        logic signed [31:0] min_limit;
        logic signed [31:0] max_limit;
        logic               busy_res;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0]            cnt;
        result_t [RES_MAX-1:0] res;
    } bundle_t;

    typedef struct packed {
        logic [31:0] joint_min;
        logic [31:0] joint_max;
        logic [31:0] home_offset;
        logic [30:0] max_fast_speed;
        logic [30:0] max_slow_speed;
        logic [30:0] backoff_angle;
    } cfg_t;

    // Saturate a 33-bit two's complement value into 32 bits.
    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            r = v[31:0];
        return r;
    endfunction

    // Twice a speed magnitude, saturated at 2^31-1.
    function automatic logic [30:0] dbl_accel(input logic [30:0] s);
        logic [30:0] r;
        r = s[30] ? 31'h7FFF_FFFF : {s[29:0], 1'b0};
        return r;
    endfunction

    function automatic result_t mk_res(input cmd_t cmd, input logic [2:0] jt,
                                       input logic [31:0] pos, input logic [31:0] spd,
                                       input logic [30:0] acc, input logic [31:0] mn,
                                       input logic [31:0] mx);
        result_t r;
        r.command      = cmd;
        r.target_joint = jt;
        r.position     = pos;
        r.speed        = spd;
        r.accel        = acc;
        r.min_limit    = mn;
        r.max_limit    = mx;
        r.busy_res     = 1'b0;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

>>> rtl/lshs_cfg.sv
// Configuration register file of the homing sequencer.
// Depends on lshs_pkg for the register index codes and the cfg_t bundle.
module lshs_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output lshs_pkg::cfg_t      cfg
);

    lshs_pkg::cfg_t cfg_reg;
    lshs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lshs_pkg::REG_JOINT_MIN:   cfg_next.joint_min      = cfg_data;
                lshs_pkg::REG_JOINT_MAX:   cfg_next.joint_max      = cfg_data;
                lshs_pkg::REG_HOME_OFFSET: cfg_next.home_offset    = cfg_data;
                lshs_pkg::REG_MAX_FAST:    cfg_next.max_fast_speed = cfg_data[30:0];
                lshs_pkg::REG_MAX_SLOW:    cfg_next.max_slow_speed = cfg_data[30:0];
                lshs_pkg::REG_BACKOFF:     cfg_next.backoff_angle  = cfg_data[30:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.joint_min      <= '0;
            cfg_reg.joint_max      <= '0;
            cfg_reg.home_offset    <= '0;
            cfg_reg.max_fast_speed <= '0;
            cfg_reg.max_slow_speed <= '0;
            cfg_reg.backoff_angle  <= lshs_pkg::BACKOFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/lshs_core.sv
// Homing phase machine, speed and limit storage, and result bundle builder.
// Depends on lshs_pkg for item, result, bundle and configuration types.
module lshs_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  lshs_pkg::item_t      item,
    input  lshs_pkg::cfg_t       cfg,
    output lshs_pkg::bundle_t    bundle
);

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_FAST    = 5'b00010,
        PH_BACKOFF = 5'b00100,
        PH_SLOW    = 5'b01000,
        PH_FINAL   = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  active_joint_reg, active_joint_next;
    logic [30:0] fast_speed_reg, fast_speed_next;
    logic [30:0] slow_speed_reg, slow_speed_next;
    logic        switch_cleared_reg, switch_cleared_next;
    logic [31:0] done_min_reg, done_max_reg;
    logic [31:0] umin_reg [lshs_pkg::JOINTS];
    logic [31:0] umax_reg [lshs_pkg::JOINTS];

    logic        lim_we;
    logic [31:0] lim_min, lim_max;
    logic [31:0] q_min, q_max;
    logic [30:0] clamp_fast, clamp_slow;
    logic [2:0]  aj;
    logic        busy;

    assign aj         = active_joint_reg;
    assign clamp_fast = (item.req_fast < cfg.max_fast_speed) ? item.req_fast
                                                             : cfg.max_fast_speed;
    assign clamp_slow = (item.req_slow < cfg.max_slow_speed) ? item.req_slow
                                                             : cfg.max_slow_speed;
    assign lim_min = lshs_pkg::sat33({cfg.joint_min[31], cfg.joint_min}
                                     - {cfg.home_offset[31], cfg.home_offset});
    assign lim_max = lshs_pkg::sat33({cfg.joint_max[31], cfg.joint_max}
                                     - {cfg.home_offset[31], cfg.home_offset});

    always_comb
    begin
        if (32'(item.joint) < lshs_pkg::JOINTS)
        begin
            q_min = umin_reg[item.joint[lshs_pkg::JIDX_W-1:0]];
            q_max = umax_reg[item.joint[lshs_pkg::JIDX_W-1:0]];
        end
        else
        begin
            q_min = '0;
            q_max = '0;
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        active_joint_next   = active_joint_reg;
        fast_speed_next     = fast_speed_reg;
        slow_speed_next     = slow_speed_reg;
        switch_cleared_next = switch_cleared_reg;
        lim_we              = 1'b0;
        bundle              = '0;

        case (item.opcode)
            lshs_pkg::OP_START:
            begin
                if (phase_reg == PH_IDLE && 32'(item.joint) < lshs_pkg::JOINTS)
                begin
                    fast_speed_next   = clamp_fast;
                    slow_speed_next   = clamp_slow;
                    active_joint_next = item.joint;
                    bundle.res[0] = lshs_pkg::mk_res(lshs_pkg::CMD_JOG, item.joint, '0,
                                                     32'd0 - {1'b0, clamp_fast},
                                                     lshs_pkg::dbl_accel(clamp_fast),
                                                     '0, '0);
                    bundle.cnt = 2'd1;
                    phase_next = PH_FAST;
                end
            end
            lshs_pkg::OP_QUERY:
            begin
                bundle.res[0] = lshs_pkg::mk_res(lshs_pkg::CMD_NONE, item.joint, '0, '0,
                                                 '0, q_min, q_max);
                bundle.cnt = 2'd1;
            end
            default:
            begin
                if (item.opcode == lshs_pkg::OP_ABORT || item.estop)
                begin
                    bundle.res[0] = lshs_pkg::mk_res(lshs_pkg::CMD_STOPJOG, aj, '0, '0,
                                                     '0, '0, '0);
                    bundle.res[1] = lshs_pkg::mk_res(lshs_pkg::CMD_STOPALL, 3'd0, '0, '0,
                                                     '0, '0, '0);
                    bundle.cnt = 2'd2;
                    phase_next = PH_IDLE;
                end
                else if (32'(aj) < lshs_pkg::JOINTS)
                begin
                    unique case (phase_reg)
                        PH_FAST:
                        begin
                            if (item.limit_hit)
                            begin
                                bundle.res[0] = lshs_pkg::mk_res(lshs_pkg::CMD_STOPJOG,
                                                aj, '0, '0, '0, '0, '0);
                                bundle.res[1] = lshs_pkg::mk_res(lshs_pkg::CMD_SETPOS,
                                                aj, cfg.joint_min, '0, '0, '0, '0);
                                bundle.res[2] = lshs_pkg::mk_res(lshs_pkg::CMD_MOVE, aj,
                                                lshs_pkg::sat33({cfg.joint_min[31],
                                                    cfg.joint_min}
                                                    + {2'b00, cfg.backoff_angle}),
                                                {1'b0, fast_speed_reg},
                                                lshs_pkg::dbl_accel(fast_speed_reg),
                                                '0, '0);
                                bundle.cnt          = 2'd3;
                                switch_cleared_next = 1'b0;
                                phase_next          = PH_BACKOFF;
                            end
                        end
                        PH_BACKOFF:
                        begin
                            if (!item.joint_moving && !item.limit_hit)
                            begin
                                if (!switch_cleared_reg)
                                begin
                                    switch_cleared_next = 1'b1;
                                end
                                else
                                begin
                                    bundle.res[0] = lshs_pkg::mk_res(lshs_pkg::CMD_JOG,
                                                    aj, '0,
                                                    32'd0 - {1'b0, slow_speed_reg},
                                                    lshs_pkg::dbl_accel(slow_speed_reg),
                                                    '0, '0);
                                    bundle.cnt = 2'd1;
                                    phase_next = PH_SLOW;
                                end
                            end
                        end
                        PH_SLOW:
                        begin
                            if (item.limit_hit)
                            begin
                                bundle.res[0] = lshs_pkg::mk_res(lshs_pkg::CMD_STOPJOG,
                                                aj, '0, '0, '0, '0, '0);
                                bundle.res[1] = lshs_pkg::mk_res(lshs_pkg::CMD_SETPOS,
                                                aj, cfg.joint_min, '0, '0, '0, '0);
                                bundle.res[2] = lshs_pkg::mk_res(lshs_pkg::CMD_MOVE, aj,
                                                cfg.home_offset,
                                                {1'b0, fast_speed_reg},
                                                lshs_pkg::dbl_accel(fast_speed_reg),
                                                '0, '0);
                                bundle.cnt = 2'd3;
                                lim_we     = 1'b1;
                                phase_next = PH_FINAL;
                            end
                        end
                        PH_FINAL:
                        begin
                            if (!item.joint_moving)
                            begin
                                bundle.res[0] = lshs_pkg::mk_res(lshs_pkg::CMD_SETPOS,
                                                aj, '0, '0, '0, '0, '0);
                                bundle.res[1] = lshs_pkg::mk_res(lshs_pkg::CMD_DONE,
                                                aj, '0, '0, '0, done_min_reg,
                                                done_max_reg);
                                bundle.cnt = 2'd2;
                                phase_next = PH_IDLE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        endcase

        // Busy reflects the phase after this item; last marks the final result.
        busy = (phase_next != PH_IDLE);
        for (int k = 0; k < lshs_pkg::RES_MAX; k++)
        begin
            bundle.res[k].busy_res = (2'(k) < bundle.cnt) ? busy : 1'b0;
            bundle.res[k].last     = (2'(k + 1) == bundle.cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            active_joint_reg   <= '0;
            fast_speed_reg     <= '0;
            slow_speed_reg     <= '0;
            switch_cleared_reg <= 1'b0;
            done_min_reg       <= '0;
            done_max_reg       <= '0;
            for (int j = 0; j < lshs_pkg::JOINTS; j++)
            begin
                umin_reg[j] <= '0;
                umax_reg[j] <= '0;
            end
        end
        else if (fire)
        begin
            phase_reg          <= phase_next;
            active_joint_reg   <= active_joint_next;
            fast_speed_reg     <= fast_speed_next;
            slow_speed_reg     <= slow_speed_next;
            switch_cleared_reg <= switch_cleared_next;
            if (lim_we)
            begin
                // Keep a copy for the done report so the table has one read port.
                done_min_reg                          <= lim_min;
                done_max_reg                          <= lim_max;
                umin_reg[aj[lshs_pkg::JIDX_W-1:0]] <= lim_min;
                umax_reg[aj[lshs_pkg::JIDX_W-1:0]] <= lim_max;
            end
        end
    end

    a_abort_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.opcode == lshs_pkg::OP_ABORT) |=> (phase_reg == PH_IDLE))
        else $error("abort did not return the sequencer to idle");

    a_active_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (32'(active_joint_reg) < lshs_pkg::JOINTS))
        else $error("busy with an active joint out of range");

endmodule

>>> rtl/lshs_emit.sv
// Result serializer: holds one bundle of up to three results and shifts them out.
// Depends on lshs_pkg for the bundle and result types.
module lshs_emit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lshs_pkg::bundle_t    bundle,
    output logic                 load_ok,
    output logic                 result_valid,
    input  logic                 result_ready,
    output lshs_pkg::result_t    result_data
);

    lshs_pkg::result_t res_reg [lshs_pkg::RES_MAX];
    logic              vld_reg, vld_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              xfer;

    assign xfer         = vld_reg && result_ready;
    assign load_ok      = !vld_reg || (cnt_reg == 2'd1 && result_ready);
    assign result_valid = vld_reg;
    assign result_data  = res_reg[0];

    always_comb
    begin
        vld_next = vld_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            vld_next = 1'b1;
            cnt_next = bundle.cnt;
        end
        else if (xfer)
        begin
            vld_next = (cnt_reg != 2'd1);
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

    // Payload: load a whole bundle, or advance to the next result on a transfer.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < lshs_pkg::RES_MAX; k++)
            begin
                res_reg[k] <= bundle.res[k];
            end
        end
        else if (xfer)
        begin
            for (int k = 0; k < lshs_pkg::RES_MAX - 1; k++)
            begin
                res_reg[k] <= res_reg[k + 1];
            end
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> load_ok)
        else $error("bundle loaded over results not yet delivered");

    a_last_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg |-> (res_reg[0].last == (cnt_reg == 2'd1)))
        else $error("last flag out of step with remaining result count");

endmodule

>>> rtl/limit_switch_homing_sequencer_top.sv
// Top level of the two-pass limit switch homing sequencer.
// Depends on lshs_pkg, lshs_cfg, lshs_core and lshs_emit.
//
// Homing sequencer for one joint at a time. Items (start, tick, abort, query)
// enter on the item channel, are held in an input register, and are resolved
// combinationally into a bundle of zero to three commands, which the result
// serializer hands out one per cycle while the result port is ready. An item is
// taken every cycle as long as the serializer can take its bundle: an item with
// k results occupies the single result port until all k have transferred, and
// the next bundle loads as its last result transfers. Items that produce no
// result (ignored starts, idle ticks, the first open read while backing off)
// retire even while earlier results are still waiting. The first result of an
// item is presented on the result port from the serializer register, after the
// item has passed the input register and been loaded into the serializer.
// Configuration writes are taken at any cycle and must only be issued while no
// item is in flight. All positions and speeds are signed Q16.16; sums saturate.
module limit_switch_homing_sequencer_top
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_ready,
    input  lshs_pkg::item_t     item_data,

    output logic                result_valid,
    input  logic                result_ready,
    output lshs_pkg::result_t   result_data,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    lshs_pkg::item_t   item_reg;
    logic              item_vld_reg, item_vld_next;
    lshs_pkg::cfg_t    cfg;
    lshs_pkg::bundle_t bundle;
    logic              load_ok;
    logic              advance;
    logic              load;

    // Retire the held item when its results fit in the serializer, or it has none.
    assign advance    = item_vld_reg && (bundle.cnt == 2'd0 || load_ok);
    assign load       = advance && (bundle.cnt != 2'd0);
    assign item_ready = !item_vld_reg || advance;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        if (item_ready)
        begin
            item_vld_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
        end
    end

    // Capture the item payload on every transfer.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item_data;
        end
    end

    lshs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lshs_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .bundle (bundle)
    );

    lshs_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .bundle       (bundle),
        .load_ok      (load_ok),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for limit_switch_homing_sequencer_top.
// Depends on lshs_pkg and the RTL of the block; it needs no other file.

module tb_top;

    import lshs_pkg::*;

    // Homing phases as the predictor tracks them.
    typedef enum logic [2:0] {
        HM_IDLE,
        HM_FAST,
        HM_BACKOFF,
        HM_SLOW,
        HM_FINAL
    } homing_phase_t;

    localparam int          RESET_CYCLES   = 12;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_ITEMS   = 320;
    localparam int          RANDOM_PHASES  = 6;
    localparam int          PASS_STEP_CAP  = 40;
    // No register lives at this index; writes to it must be dropped.
    localparam logic [2:0]  REG_SPARE      = 3'd7;

    localparam logic signed [33:0] Q_MAX = 34'sd2147483647;
    localparam logic signed [33:0] Q_MIN = -34'sd2147483648;

    // ------------------------------------------------------------------
    // Clock, reset and the ports of the block
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n        = 1'b0;

    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item_data    = '0;

    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result_data;

    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = '0;
    logic [31:0] cfg_data     = '0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    limit_switch_homing_sequencer_top u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the sequencer
    // ------------------------------------------------------------------
    logic [31:0]   cfg_joint_min   = '0;
    logic [31:0]   cfg_joint_max   = '0;
    logic [31:0]   cfg_home_offset = '0;
    logic [30:0]   cfg_max_fast    = '0;
    logic [30:0]   cfg_max_slow    = '0;
    logic [30:0]   cfg_backoff     = BACKOFF_RESET;

    homing_phase_t hm_phase        = HM_IDLE;
    logic [2:0]    act_joint       = '0;
    logic [30:0]   fast_spd        = '0;
    logic [30:0]   slow_spd        = '0;
    bit            sw_cleared      = 1'b0;
    logic [31:0]   homed_min [JOINTS] = '{default: '0};
    logic [31:0]   homed_max [JOINTS] = '{default: '0};

    // Commands still owed by the block, oldest first.
    result_t       pending_cmds[$];

    int unsigned   mismatches      = 0;
    int unsigned   items_sent      = 0;

    // Sender bookkeeping: item_held means valid stays high into the next send.
    bit            item_held       = 1'b0;
    int unsigned   item_gap        = 1;
    bit            pacing          = 1'b1;

    // ------------------------------------------------------------------
    // Arithmetic helpers in Q16.16
    // ------------------------------------------------------------------
    function automatic logic signed [33:0] widen_s(input logic [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic signed [33:0] widen_u(input logic [30:0] v);
        return {3'b000, v};
    endfunction

    // Clamp a wide sum back into the signed 32-bit range.
    function automatic logic [31:0] clamp_q(input logic signed [33:0] v);
        if (v > Q_MAX)
            return 32'h7FFF_FFFF;
        if (v < Q_MIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Acceleration is twice the speed, pinned at the 31-bit ceiling.
    function automatic logic [30:0] accel_of(input logic [30:0] s);
        logic [31:0] d;
        d = {s, 1'b0};
        return (d > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : d[30:0];
    endfunction

    function automatic logic [31:0] reverse_speed(input logic [30:0] s);
        return -{1'b0, s};
    endfunction

    function automatic result_t compose_cmd(input cmd_t c, input logic [2:0] j,
                                            input logic [31:0] pos, input logic [31:0] spd,
                                            input logic [30:0] acc, input logic [31:0] lo,
                                            input logic [31:0] hi);
        result_t r;
        r              = '0;
        r.command      = c;
        r.target_joint = j;
        r.position     = pos;
        r.speed        = spd;
        r.accel        = acc;
        r.min_limit    = lo;
        r.max_limit    = hi;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: advance the private state by one item and queue the
    // commands it causes.
    // ------------------------------------------------------------------
    function automatic void predict_commands(input item_t it);
        result_t            batch[$];
        logic signed [33:0] jmin;
        logic signed [33:0] jmax;
        logic signed [33:0] hoff;
        jmin = widen_s(cfg_joint_min);
        jmax = widen_s(cfg_joint_max);
        hoff = widen_s(cfg_home_offset);

        if (it.opcode == OP_START)
        begin
            // Ignore a start while busy or for a joint that does not exist.
            if (hm_phase == HM_IDLE && it.joint < JOINTS)
            begin
                fast_spd  = (it.req_fast < cfg_max_fast) ? it.req_fast : cfg_max_fast;
                slow_spd  = (it.req_slow < cfg_max_slow) ? it.req_slow : cfg_max_slow;
                act_joint = it.joint;
                batch.push_back(compose_cmd(CMD_JOG, act_joint, '0, reverse_speed(fast_spd),
                                            accel_of(fast_spd), '0, '0));
                hm_phase  = HM_FAST;
            end
        end
        else if (it.opcode == OP_QUERY)
        begin
            if (it.joint < JOINTS)
                batch.push_back(compose_cmd(CMD_NONE, it.joint, '0, '0, '0,
                                            homed_min[it.joint], homed_max[it.joint]));
            else
                batch.push_back(compose_cmd(CMD_NONE, it.joint, '0, '0, '0, '0, '0));
        end
        else if (it.opcode == OP_ABORT || it.estop)
        begin
            // Stop both ways, even from idle.
            batch.push_back(compose_cmd(CMD_STOPJOG, act_joint, '0, '0, '0, '0, '0));
            batch.push_back(compose_cmd(CMD_STOPALL, 3'd0, '0, '0, '0, '0, '0));
            hm_phase = HM_IDLE;
        end
        else
        begin
            case (hm_phase)
                HM_FAST:
                    if (it.limit_hit)
                    begin
                        batch.push_back(compose_cmd(CMD_STOPJOG, act_joint, '0, '0, '0, '0, '0));
                        batch.push_back(compose_cmd(CMD_SETPOS, act_joint, jmin[31:0],
                                                    '0, '0, '0, '0));
                        batch.push_back(compose_cmd(CMD_MOVE, act_joint,
                                                    clamp_q(jmin + widen_u(cfg_backoff)),
                                                    {1'b0, fast_spd}, accel_of(fast_spd),
                                                    '0, '0));
                        sw_cleared = 1'b0;
                        hm_phase   = HM_BACKOFF;
                    end
                HM_BACKOFF:
                    // The switch must read open on two idle ticks.
                    if (!it.joint_moving && !it.limit_hit)
                    begin
                        if (!sw_cleared)
                        begin
                            sw_cleared = 1'b1;
                        end
                        else
                        begin
                            batch.push_back(compose_cmd(CMD_JOG, act_joint, '0,
                                                        reverse_speed(slow_spd),
                                                        accel_of(slow_spd), '0, '0));
                            hm_phase = HM_SLOW;
                        end
                    end
                HM_SLOW:
                    if (it.limit_hit)
                    begin
                        batch.push_back(compose_cmd(CMD_STOPJOG, act_joint, '0, '0, '0, '0, '0));
                        batch.push_back(compose_cmd(CMD_SETPOS, act_joint, jmin[31:0],
                                                    '0, '0, '0, '0));
                        homed_min[act_joint] = clamp_q(jmin - hoff);
                        homed_max[act_joint] = clamp_q(jmax - hoff);
                        batch.push_back(compose_cmd(CMD_MOVE, act_joint, hoff[31:0],
                                                    {1'b0, fast_spd}, accel_of(fast_spd),
                                                    '0, '0));
                        hm_phase = HM_FINAL;
                    end
                HM_FINAL:
                    if (!it.joint_moving)
                    begin
                        batch.push_back(compose_cmd(CMD_SETPOS, act_joint, '0, '0, '0, '0, '0));
                        batch.push_back(compose_cmd(CMD_DONE, act_joint, '0, '0, '0,
                                                    homed_min[act_joint],
                                                    homed_max[act_joint]));
                        hm_phase = HM_IDLE;
                    end
                default:
                    ;
            endcase
        end

        // Busy reflects the phase after the item; last marks the final command.
        foreach (batch[k])
        begin
            batch[k].busy_res = (hm_phase != HM_IDLE);
            batch[k].last     = (k == batch.size() - 1);
            pending_cmds.push_back(batch[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Item builders: fields an opcode does not use carry random junk
    // ------------------------------------------------------------------
    function automatic item_t noise_item();
        item_t it;
        it.opcode       = op_t'($urandom_range(0, 3));
        it.joint        = 3'($urandom_range(0, 7));
        it.req_fast     = 31'($urandom);
        it.req_slow     = 31'($urandom);
        it.limit_hit    = 1'($urandom_range(0, 1));
        it.joint_moving = 1'($urandom_range(0, 1));
        it.estop        = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic item_t start_item(input logic [2:0] j, input logic [30:0] rf,
                                         input logic [30:0] rs);
        item_t it;
        it          = noise_item();
        it.opcode   = OP_START;
        it.joint    = j;
        it.req_fast = rf;
        it.req_slow = rs;
        return it;
    endfunction

    function automatic item_t tick_item(input bit hit, input bit moving, input bit stop);
        item_t it;
        it              = noise_item();
        it.opcode       = OP_TICK;
        it.limit_hit    = hit;
        it.joint_moving = moving;
        it.estop        = stop;
        return it;
    endfunction

    function automatic item_t query_item(input logic [2:0] j);
        item_t it;
        it        = noise_item();
        it.opcode = OP_QUERY;
        it.joint  = j;
        return it;
    endfunction

    function automatic item_t abort_item();
        item_t it;
        it        = noise_item();
        it.opcode = OP_ABORT;
        return it;
    endfunction

    // Speeds lean toward the edges: zero, full scale, small, or anything.
    function automatic logic [30:0] pick_speed();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom_range(1, 32'h000F_FFFF));
            default: return 31'($urandom);
        endcase
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Send one item. When the next gap is zero, hold valid high so the next
    // call only swaps the payload in the same time step.
    task automatic send_item(input item_t it);
        int unsigned g;
        if (!item_held)
            repeat (item_gap) @(posedge clk);
        item_valid <= 1'b1;
        item_data  <= it;
        do @(posedge clk); while (!item_ready);
        predict_commands(it);
        items_sent++;
        g         = pacing ? pick_gap() : 0;
        item_held = (g == 0);
        item_gap  = g;
        if (!item_held)
            item_valid <= 1'b0;
    endtask

    // Drop valid, wait for every owed command, then let the pipeline drain
    // items that produce nothing before anyone touches the registers.
    task automatic finish_traffic();
        if (item_held)
        begin
            item_valid <= 1'b0;
            item_held   = 1'b0;
        end
        item_gap = 1;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_JOINT_MIN:   cfg_joint_min   = val;
            REG_JOINT_MAX:   cfg_joint_max   = val;
            REG_HOME_OFFSET: cfg_home_offset = val;
            REG_MAX_FAST:    cfg_max_fast    = val[30:0];
            REG_MAX_SLOW:    cfg_max_slow    = val[30:0];
            REG_BACKOFF:     cfg_backoff     = val[30:0];
            default:         ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: alternate ready runs with stalls while pacing is on.
    initial
    begin : result_pacing
        forever
        begin
            @(posedge clk);
            result_ready <= 1'b1;
            if (pacing)
            begin
                repeat ($urandom_range(1, 16)) @(posedge clk);
                result_ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void cmp_field(input string nm, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %08h, actual %08h", $time, nm, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no command, actual command %0d joint %0d",
                         $time, result_data.command, result_data.target_joint);
            end
            else
            begin
                want = pending_cmds.pop_front();
                cmp_field("command",      32'(want.command),
                          32'(result_data.command));
                cmp_field("target_joint", 32'(want.target_joint),
                          32'(result_data.target_joint));
                cmp_field("position",     want.position,     result_data.position);
                cmp_field("speed",        want.speed,        result_data.speed);
                cmp_field("accel",        32'(want.accel),   32'(result_data.accel));
                cmp_field("min_limit",    want.min_limit,    result_data.min_limit);
                cmp_field("max_limit",    want.max_limit,    result_data.max_limit);
                cmp_field("busy_res",     32'(want.busy_res),
                          32'(result_data.busy_res));
                cmp_field("last",         32'(want.last),    32'(result_data.last));
            end
        end
    end

    // Watchdog: give up after a long stretch with no transfer on any channel.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("limit_switch_homing_sequencer_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Requests against an idle block with the reset register values:
    // queries of real and missing joints, idle ticks, stops from idle,
    // starts for missing joints, and a start that clamps to zero speed.
    task automatic test_idle_requests();
        send_item(query_item(3'd0));
        send_item(query_item(3'd7));
        send_item(tick_item(1'b0, 1'b0, 1'b0));
        send_item(tick_item(1'b1, 1'b1, 1'b1));
        send_item(abort_item());
        send_item(start_item(3'd6, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(start_item(3'd7, 31'd1, 31'd1));
        send_item(start_item(3'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(start_item(3'd1, 31'd5, 31'd5));
        send_item(abort_item());
        finish_traffic();
    endtask

    // One full homing run with registers at the edges, so the backoff target, the
    // homed minimum and the doubled speeds saturate; also a busy start, a busy query,
    // and a hit while backing off that must not count as an open read.
    task automatic test_saturating_homing();
        write_reg(REG_JOINT_MIN,   32'h7FFF_0000);
        write_reg(REG_JOINT_MAX,   32'h8000_0000);
        write_reg(REG_HOME_OFFSET, 32'h8000_0000);
        write_reg(REG_MAX_FAST,    32'h7FFF_FFFF);
        write_reg(REG_MAX_SLOW,    32'hC000_0000);
        write_reg(REG_BACKOFF,     32'hFFFF_FFFF);
        write_reg(REG_SPARE,       32'h1234_5678);
        send_item(start_item(3'd5, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(start_item(3'd1, 31'd9, 31'd9));
        send_item(query_item(3'd5));
        send_item(tick_item(1'b0, 1'b0, 1'b0));
        send_item(tick_item(1'b1, 1'b1, 1'b0));
        send_item(tick_item(1'b0, 1'b1, 1'b0));
        send_item(tick_item(1'b0, 1'b0, 1'b0));
        send_item(tick_item(1'b1, 1'b0, 1'b0));
        send_item(tick_item(1'b0, 1'b0, 1'b0));
        send_item(tick_item(1'b0, 1'b1, 1'b0));
        send_item(tick_item(1'b1, 1'b1, 1'b0));
        send_item(tick_item(1'b0, 1'b1, 1'b0));
        send_item(tick_item(1'b0, 1'b0, 1'b0));
        send_item(query_item(3'd5));
        finish_traffic();
    endtask

    // E-stop on a tick in the middle of a fast approach.
    task automatic test_estop_during_homing();
        send_item(start_item(3'd2, 31'h0002_0000, 31'h0000_8000));
        send_item(tick_item(1'b1, 1'b0, 1'b1));
        finish_traffic();
    endtask

    // One homing attempt with random content, steered by the predicted phase
    // so most ticks move the sequence forward; queries, stray starts, aborts
    // and e-stops are mixed in.
    task automatic run_homing_pass();
        logic [2:0]  j;
        int unsigned r;
        int unsigned steps;
        bit          hit;
        bit          moving;
        j = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(JOINTS, 7))
                                         : 3'($urandom_range(0, JOINTS - 1));
        send_item(start_item(j, pick_speed(), pick_speed()));
        steps = 0;
        while (hm_phase != HM_IDLE && steps < PASS_STEP_CAP)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_item(query_item(3'($urandom_range(0, 7))));
            end
            else if (r < 10)
            begin
                send_item(abort_item());
            end
            else if (r < 12)
            begin
                send_item(start_item(3'($urandom_range(0, 7)), pick_speed(), pick_speed()));
            end
            else
            begin
                hit    = 1'($urandom_range(0, 1));
                moving = 1'($urandom_range(0, 1));
                case (hm_phase)
                    HM_FAST, HM_SLOW:
                        hit = ($urandom_range(0, 2) == 0);
                    HM_BACKOFF:
                        if ($urandom_range(0, 1))
                        begin
                            hit    = 1'b0;
                            moving = 1'b0;
                        end
                    default:
                        moving = ($urandom_range(0, 1) == 0);
                endcase
                send_item(tick_item(hit, moving, $urandom_range(0, 59) == 0));
            end
            steps++;
        end
    endtask

    // Several register settings in turn, the first one with no idling on
    // either side, the second at fixed extremes; all others, the first
    // included, pick values near the edges or at random.
    task automatic test_random_homing();
        int unsigned goal;
        logic [31:0] val;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pacing = (p != 0);
            if (p == 1)
            begin
                write_reg(REG_JOINT_MIN,   32'h8000_0000);
                write_reg(REG_JOINT_MAX,   32'h8000_0000);
                write_reg(REG_HOME_OFFSET, 32'h7FFF_FFFF);
                write_reg(REG_MAX_FAST,    32'h0000_0000);
                write_reg(REG_MAX_SLOW,    32'h7FFF_FFFF);
                write_reg(REG_BACKOFF,     32'h0000_0000);
            end
            else
            begin
                for (int k = REG_JOINT_MIN; k <= REG_BACKOFF; k++)
                begin
                    case ($urandom_range(0, 5))
                        0:       val = 32'h0000_0000;
                        1:       val = 32'h8000_0000;
                        2:       val = 32'h7FFF_FFFF;
                        3:       val = 32'hFFFF_FFFF;
                        4:       val = $urandom_range(0, 32'h0040_0000);
                        default: val = $urandom;
                    endcase
                    write_reg(3'(k), val);
                end
            end
            write_reg(REG_SPARE, $urandom);
            goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 9) < 8)
                    run_homing_pass();
                else
                    repeat ($urandom_range(1, 4)) send_item(noise_item());
            end
            finish_traffic();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_requests();
        test_saturating_homing();
        test_estop_during_homing();
        test_random_homing();
        if (mismatches == 0)
            $display("limit_switch_homing_sequencer_top test passed");
        else
            $display("limit_switch_homing_sequencer_top test failed");
        $finish;
    end

endmodule
